/* rtl/core/pcxd_pkg.sv */
// ============================================================================
// pcxd_pkg - shared types and constants of the PCX scan-line decoder
// Widths, register indexes, item structs and the palette word packing.
// ============================================================================
package pcxd_pkg;

    // Palette and run sizing
    localparam int PALETTE_ENTRIES = 256;
    localparam int RUN_MAX         = 63;
    localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int RUN_W           = $clog2(RUN_MAX + 1);

    // Field widths
    localparam int PIXEL_W = 16;
    localparam int LINE_W  = 16;
    localparam int BYTE_W  = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_LINE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_MODE    = 1'd1;
    localparam logic [LINE_W-1:0]    RESET_BYTES_PER_LINE = 16'd640;

    // Stream coding
    localparam logic       OP_IMAGE   = 1'b0;
    localparam logic       OP_PALETTE = 1'b1;
    localparam logic [7:0] RUN_MARK   = 8'hC0;
    localparam logic [5:0] COUNT_MASK = 6'h3F;

    typedef struct packed {
        logic       opcode;
        logic [7:0] byte_value;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               last;
        logic               line_end;
        logic               overrun;
    } out_item_t;

    // Controller -> datapath
    typedef struct packed {
        logic accept;   // input transfer this cycle
        logic emit;     // load one pixel into the output register
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic starts_job;   // offered item produces at least one pixel
        logic final_px;     // pixel being built ends the current job
        logic out_free;     // output register can take a pixel
    } status_t;

    // 5-5-5 packing: red [15:11], green [10:6], bit 5 clear, blue [4:0]
    function automatic logic [PIXEL_W-1:0] pal_word(input logic [7:0] r,
                                                    input logic [7:0] g,
                                                    input logic [7:0] b);
        pal_word = {r[7:3], g[7:3], 1'b0, b[7:3]};
    endfunction

endpackage

/* rtl/core/pcxd_channels.sv */
// ============================================================================
// pcxd channels - valid/ready stream interfaces of the decoder
// Input carries compressed bytes and palette writes, output carries pixels.
// ============================================================================
interface pcxd_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] byte_value;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, opcode, byte_value, entry_index, red, green, blue,
                    input ready);
    modport sink   (input valid, opcode, byte_value, entry_index, red, green, blue,
                    output ready);
endinterface

interface pcxd_out_if;
    logic                       valid;
    logic                       ready;
    logic [pcxd_pkg::PIXEL_W-1:0] pixel;
    logic                       last;
    logic                       line_end;
    logic                       overrun;

    modport source (output valid, pixel, last, line_end, overrun, input ready);
    modport sink   (input valid, pixel, last, line_end, overrun, output ready);
endinterface

/* rtl/core/pcxd_ram.sv */
// ============================================================================
// pcxd_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ============================================================================
module pcxd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/pcxd_ctrl.sv */
// ============================================================================
// pcxd_ctrl - decoder sequencer
// Takes input transfers and steps pixel emission of literals and runs.
// ============================================================================
module pcxd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pcxd_pkg::status_t st,
    output pcxd_pkg::cmd_t    cmd
);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   emit;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && st.starts_job)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                emit     = st.out_free;
                // next item may enter as the final pixel of this one leaves
                in_ready = st.out_free && st.final_px;
                if (in_ready)
                begin
                    state_next = (in_valid && st.starts_job) ? S_EMIT : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cmd.accept = in_valid && in_ready;
    assign cmd.emit   = emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/pcxd_dp.sv */
// ============================================================================
// pcxd_dp - decoder datapath
// Run state, line position, palette RAM, config registers, output register.
// ============================================================================
module pcxd_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [pcxd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcxd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  pcxd_pkg::in_item_t                  item,
    input  pcxd_pkg::cmd_t                      cmd,
    output pcxd_pkg::status_t                   st,
    input  logic                                out_ready,
    output logic                                out_valid,
    output pcxd_pkg::out_item_t                 out_item
);

    // Configuration
    logic [pcxd_pkg::LINE_W-1:0] bpl_reg;
    logic                        colour_reg;

    // Run decoding
    logic                        awaiting_reg, awaiting_next;
    logic [pcxd_pkg::RUN_W-1:0]  pending_reg, pending_next;
    logic [pcxd_pkg::RUN_W-1:0]  rem_reg, rem_next;
    logic [7:0]                  val_reg, val_next;
    logic [pcxd_pkg::LINE_W-1:0] pil_reg, pil_next;

    // Output register
    logic                        out_valid_reg, out_valid_next;
    pcxd_pkg::out_item_t         out_item_reg;

    // Header count, saturated
    logic [5:0]                  hdr_count;
    logic [pcxd_pkg::RUN_W-1:0]  hdr_sat;
    logic                        is_header;

    // Line end
    logic [pcxd_pkg::LINE_W:0]   line_count;
    logic [pcxd_pkg::LINE_W:0]   line_limit;
    logic                        at_end;

    // Palette
    logic                        pal_we;
    logic [pcxd_pkg::PAL_AW-1:0] pal_rd_addr;
    logic [pcxd_pkg::PIXEL_W-1:0] pal_rd_data;
    logic [pcxd_pkg::PIXEL_W-1:0] px_word;

    localparam logic [8:0] PAL_LIMIT = 9'(pcxd_pkg::PALETTE_ENTRIES);
    localparam logic [5:0] RUN_CAP   = 6'(pcxd_pkg::RUN_MAX);

    assign hdr_count = item.byte_value[5:0] & pcxd_pkg::COUNT_MASK;
    assign hdr_sat   = (hdr_count > RUN_CAP) ? pcxd_pkg::RUN_W'(RUN_CAP)
                                             : pcxd_pkg::RUN_W'(hdr_count);
    assign is_header = item.byte_value >= pcxd_pkg::RUN_MARK;

    assign st.starts_job = (item.opcode == pcxd_pkg::OP_IMAGE) &&
                           (awaiting_reg ? (pending_reg != '0) : !is_header);

    // 0 stands for a 65536-pixel line
    assign line_count = {1'b0, pil_reg} + 17'd1;
    assign line_limit = (bpl_reg == '0) ? 17'h10000 : {1'b0, bpl_reg};
    assign at_end     = line_count >= line_limit;

    assign st.final_px = at_end || (rem_reg == pcxd_pkg::RUN_W'(1));
    assign st.out_free = !out_valid_reg || out_ready;

    // Read address follows the byte being taken, else holds on the job value
    assign pal_we      = cmd.accept && (item.opcode == pcxd_pkg::OP_PALETTE) &&
                         ({1'b0, item.entry_index} < PAL_LIMIT);
    assign pal_rd_addr = cmd.accept ? item.byte_value[pcxd_pkg::PAL_AW-1:0]
                                    : val_reg[pcxd_pkg::PAL_AW-1:0];

    pcxd_ram #(
        .WIDTH (pcxd_pkg::PIXEL_W),
        .DEPTH (pcxd_pkg::PALETTE_ENTRIES)
    ) u_palette (
        .clk     (clk),
        .wr_en   (pal_we),
        .wr_addr (item.entry_index[pcxd_pkg::PAL_AW-1:0]),
        .wr_data (pcxd_pkg::pal_word(item.red, item.green, item.blue)),
        .rd_addr (pal_rd_addr),
        .rd_data (pal_rd_data)
    );

    always_comb
    begin
        if (!colour_reg)
        begin
            px_word = {8'h00, val_reg};
        end
        else if ({1'b0, val_reg} < PAL_LIMIT)
        begin
            px_word = pal_rd_data;
        end
        else
        begin
            px_word = '0;
        end
    end

    always_comb
    begin
        awaiting_next = awaiting_reg;
        pending_next  = pending_reg;
        rem_next      = rem_reg;
        val_next      = val_reg;
        pil_next      = pil_reg;

        if (cmd.emit)
        begin
            rem_next = rem_reg - pcxd_pkg::RUN_W'(1);
            pil_next = at_end ? '0 : line_count[pcxd_pkg::LINE_W-1:0];
        end

        if (cmd.accept && (item.opcode == pcxd_pkg::OP_IMAGE))
        begin
            priority if (awaiting_reg)
            begin
                awaiting_next = 1'b0;
                pending_next  = '0;
                rem_next      = pending_reg;
                val_next      = item.byte_value;
            end
            else if (is_header)
            begin
                awaiting_next = 1'b1;
                pending_next  = hdr_sat;
            end
            else
            begin
                rem_next = pcxd_pkg::RUN_W'(1);
                val_next = item.byte_value;
            end
        end
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpl_reg       <= pcxd_pkg::RESET_BYTES_PER_LINE;
            colour_reg    <= 1'b0;
            awaiting_reg  <= 1'b0;
            pending_reg   <= '0;
            rem_reg       <= '0;
            pil_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en && (cfg_index == pcxd_pkg::CFG_BYTES_PER_LINE))
            begin
                bpl_reg <= cfg_data[pcxd_pkg::LINE_W-1:0];
            end
            if (cfg_wr_en && (cfg_index == pcxd_pkg::CFG_COLOUR_MODE))
            begin
                colour_reg <= cfg_data[0];
            end
            awaiting_reg  <= awaiting_next;
            pending_reg   <= pending_next;
            rem_reg       <= rem_next;
            pil_reg       <= pil_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        if (cmd.emit)
        begin
            out_item_reg.pixel    <= px_word;
            out_item_reg.last     <= at_end || (rem_reg == pcxd_pkg::RUN_W'(1));
            out_item_reg.line_end <= at_end;
            out_item_reg.overrun  <= at_end && (rem_reg > pcxd_pkg::RUN_W'(1));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* rtl/core/pcx_rle_line_decoder.sv */
// ============================================================================
// pcx_rle_line_decoder - PCX run-length scan-line decoder
// Expands compressed PCX bytes into index or 5-5-5 palette pixels per line.
// ============================================================================
//
//  Channel   Dir  Carries                                   Transfer when
//  --------  ---  ----------------------------------------  ----------------
//  stream    in   opcode, byte_value, entry_index, r/g/b    valid && ready
//  pixels    out  pixel, last, line_end, overrun            valid && ready
//  cfg_*     in   register index and data                   cfg_wr_en high
//
//  A literal byte or a run holds off the next input until its last pixel
//  is emitted; pixels step out one per emit step of the sequencer into the
//  single output register. Run headers and palette writes emit no pixel.
//  The first pixel of an item goes through the palette RAM read register,
//  loaded at its transfer edge, then the output register at an emit step.
//  Reset clears run state, line position and config to defaults; the palette
//  RAM is not cleared and holds garbage until written.
//  A stall on pixels freezes emission; the next input is taken as soon as the
//  final pixel of the current item moves into the output register.
//
module pcx_rle_line_decoder (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [pcxd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pcxd_pkg::CFG_DATA_W-1:0]  cfg_data,
    pcxd_in_if.sink                          stream,
    pcxd_out_if.source                       pixels
);

    pcxd_pkg::in_item_t  item;
    pcxd_pkg::out_item_t out_item;
    pcxd_pkg::cmd_t      cmd;
    pcxd_pkg::status_t   st;
    logic                in_ready;
    logic                out_valid;

    // Pack the input payload for the datapath
    assign item.opcode      = stream.opcode;
    assign item.byte_value  = stream.byte_value;
    assign item.entry_index = stream.entry_index;
    assign item.red         = stream.red;
    assign item.green       = stream.green;
    assign item.blue        = stream.blue;

    assign stream.ready = in_ready;

    // Sequencer: decides transfers and pixel steps
    pcxd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stream.valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath: run state, line counter, palette, output register
    pcxd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .st        (st),
        .out_ready (pixels.ready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    assign pixels.valid    = out_valid;
    assign pixels.pixel    = out_item.pixel;
    assign pixels.last     = out_item.last;
    assign pixels.line_end = out_item.line_end;
    assign pixels.overrun  = out_item.overrun;

endmodule
